@@ hw/rtl/mpfifo_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants for the multilevel priority fifo
// no dependencies: imported by mpfifo_ram users and the top level
package mpfifo_pkg;

  localparam int LEVELS  = 8;
  localparam int DEPTH   = 16;

  localparam int LVL_W   = $clog2(LEVELS);
  localparam int PTR_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int SLOT_AW = $clog2(LEVELS * DEPTH);

  // configuration register widths
  localparam int LVC_W   = 4;
  localparam int CAP_W   = 5;

  // register indexes, decoded from paddr[2]
  localparam logic [0:0] REG_LEVELS   = 1'b0;
  localparam logic [0:0] REG_CAPACITY = 1'b1;

  localparam logic [LVC_W-1:0] LEVELS_RESET   = LVC_W'(8);
  localparam logic [CAP_W-1:0] CAPACITY_RESET = CAP_W'(16);

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_META,
    S_SLOT
  } state_t;

  typedef struct packed {
    logic        operation;
    logic [3:0]  priority_req;
    logic [15:0] item_handle;
  } cmd_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] popped_handle;
  } result_t;

  // per-level ring bookkeeping, one word of the metadata memory
  typedef struct packed {
    logic [PTR_W-1:0] rd_ptr;
    logic [PTR_W-1:0] wr_ptr;
    logic [CNT_W-1:0] count;
  } meta_t;

endpackage

@@ hw/rtl/mpfifo_ram.sv @@
`timescale 1ns / 1ps
// generic single-write, single-read ram with registered read data
// no dependencies
module mpfifo_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/multilevel_priority_fifo_unit.sv @@
`timescale 1ns / 1ps
// top level of the multilevel priority fifo: command channel, result strobe,
// apb register port; depends on mpfifo_pkg and mpfifo_ram
//
//   channel   signals                                  transaction when
//   --------  ---------------------------------------  -----------------------------
//   command   start, busy, cmd (cmd_t)                 start high and busy low
//   result    done, result (result_t)                  done high, one cycle, no stall
//   config    psel, penable, pwrite, paddr, pwdata,    psel, penable, pwrite, pready
//             prdata, pready
//
// push or rejected command: busy in the cycle after acceptance (S_META), result strobe in the
//   next cycle; a pop with an entry adds the slot read (S_SLOT)
// the result waits on the metadata memory read, then the slot memory read
// a new command is taken while the previous result is on the result ports
// reset: no clearing pass; per-level valid bits make unwritten metadata read as zero
// the receiver cannot stall, results are dropped if not taken
module multilevel_priority_fifo_unit
  import mpfifo_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // command channel
  input  logic        start,
  output logic        busy,
  input  cmd_t        cmd,
  // result channel
  output logic        done,
  output result_t     result,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // ring pointer step with wrap at the effective capacity
  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] ptr,
                                               input logic [CAP_W-1:0] cap);
    logic [PTR_W:0] nxt;
    nxt = {1'b0, ptr} + (PTR_W+1)'(1);
    if (CAP_W'(nxt) >= cap || nxt >= (PTR_W+1)'(DEPTH)) begin
      nxt = '0;
    end
    return nxt[PTR_W-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [LVC_W-1:0] levels_in_use;
  logic [CAP_W-1:0] queue_capacity;
  logic             cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      levels_in_use  <= LEVELS_RESET;
      queue_capacity <= CAPACITY_RESET;
    end else if (cfg_write) begin
      case (paddr[2])
        REG_LEVELS:   levels_in_use  <= pwdata[LVC_W-1:0];
        REG_CAPACITY: queue_capacity <= pwdata[CAP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_LEVELS:   prdata = 32'(levels_in_use);
      REG_CAPACITY: prdata = 32'(queue_capacity);
      default:      prdata = '0;
    endcase
  end

  // register values clamped to what the storage supports
  logic [LVC_W-1:0] eff_levels;
  logic [CAP_W-1:0] eff_cap;

  assign eff_levels = (levels_in_use > LVC_W'(LEVELS)) ? LVC_W'(LEVELS) : levels_in_use;
  assign eff_cap    = (queue_capacity > CAP_W'(DEPTH)) ? CAP_W'(DEPTH) : queue_capacity;

  // ---------------------------------------------------------------------------
  // state and held command
  // ---------------------------------------------------------------------------
  state_t           state, state_next;
  logic             accept;
  cmd_t             cmd_q;
  logic [LVL_W-1:0] lv_q;
  logic             bad_q;           // rejected at acceptance, before any memory write
  status_t          bad_status_q;
  logic             meta_hit;        // metadata word was written since reset

  logic [LEVELS-1:0] meta_valid;
  logic [LEVELS-1:0] nonempty;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // level selection at acceptance: push takes level priority minus one, pop takes the
  // lowest-numbered nonempty level among those in use
  logic [LVL_W-1:0] sel_lv;
  logic             sel_bad;
  status_t          sel_status;
  logic             pop_found;
  logic [LVL_W-1:0] pop_lv;

  always_comb begin
    pop_found = 1'b0;
    pop_lv    = '0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (nonempty[i] && (LVC_W'(i) < eff_levels)) begin
        pop_found = 1'b1;
        pop_lv    = LVL_W'(i);
      end
    end
  end

  always_comb begin
    if (cmd.operation == OP_PUSH) begin
      sel_lv     = LVL_W'(cmd.priority_req - 4'd1);
      sel_bad    = (cmd.priority_req == 4'd0) || (LVC_W'(cmd.priority_req) > eff_levels);
      sel_status = ST_RANGE;
    end else begin
      sel_lv     = pop_lv;
      sel_bad    = !pop_found;
      sel_status = ST_EMPTY;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q        <= cmd;
      lv_q         <= sel_lv;
      bad_q        <= sel_bad;
      bad_status_q <= sel_status;
      meta_hit     <= meta_valid[sel_lv];
    end
  end

  // ---------------------------------------------------------------------------
  // memories
  // ---------------------------------------------------------------------------
  logic               meta_we;
  meta_t              meta_wdata;
  meta_t              meta_rdata;
  meta_t              meta_cur;
  logic               slot_we;
  logic               slot_re;
  logic [SLOT_AW-1:0] slot_addr;
  logic [15:0]        slot_rdata;

  mpfifo_ram #(
    .WIDTH ($bits(meta_t)),
    .DEPTH (LEVELS)
  ) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (lv_q),
    .wdata (meta_wdata),
    .re    (accept),
    .raddr (sel_lv),
    .rdata (meta_rdata)
  );

  mpfifo_ram #(
    .WIDTH (16),
    .DEPTH (LEVELS * DEPTH)
  ) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_addr),
    .wdata (cmd_q.item_handle),
    .re    (slot_re),
    .raddr (slot_addr),
    .rdata (slot_rdata)
  );

  // never-written metadata reads as the reset value
  assign meta_cur = meta_hit ? meta_rdata : '0;

  // ---------------------------------------------------------------------------
  // read-modify-write of the level metadata
  // ---------------------------------------------------------------------------
  logic    done_next;
  result_t result_next;
  logic    ne_we;
  logic    ne_val;
  logic    push_full;

  assign push_full = (CAP_W'(meta_cur.count) >= eff_cap);

  always_comb begin
    state_next  = state;
    done_next   = 1'b0;
    result_next = '{status: ST_OK, popped_handle: 16'h0000};
    meta_we     = 1'b0;
    meta_wdata  = meta_cur;
    slot_we     = 1'b0;
    slot_re     = 1'b0;
    ne_we       = 1'b0;
    ne_val      = 1'b0;
    slot_addr   = SLOT_AW'(lv_q) * SLOT_AW'(DEPTH) + SLOT_AW'(meta_cur.wr_ptr);
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_META;
        end
      end
      S_META: begin
        if (bad_q) begin
          done_next          = 1'b1;
          result_next.status = bad_status_q;
          state_next         = S_IDLE;
        end else if (cmd_q.operation == OP_PUSH) begin
          done_next  = 1'b1;
          state_next = S_IDLE;
          if (push_full) begin
            result_next.status = ST_FULL;
          end else begin
            slot_we           = 1'b1;
            meta_we           = 1'b1;
            meta_wdata.wr_ptr = advance(meta_cur.wr_ptr, eff_cap);
            meta_wdata.count  = meta_cur.count + CNT_W'(1);
            ne_we             = 1'b1;
            ne_val            = 1'b1;
          end
        end else begin
          // pop: slot read now; the read data is taken in S_SLOT and registered into the result
          slot_addr         = SLOT_AW'(lv_q) * SLOT_AW'(DEPTH) + SLOT_AW'(meta_cur.rd_ptr);
          slot_re           = 1'b1;
          meta_we           = 1'b1;
          meta_wdata.rd_ptr = advance(meta_cur.rd_ptr, eff_cap);
          meta_wdata.count  = meta_cur.count - CNT_W'(1);
          ne_we             = 1'b1;
          ne_val            = (meta_cur.count != CNT_W'(1));
          state_next        = S_SLOT;
        end
      end
      S_SLOT: begin
        done_next                 = 1'b1;
        result_next.popped_handle = slot_rdata;
        state_next                = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      done       <= 1'b0;
      meta_valid <= '0;
      nonempty   <= '0;
    end else begin
      state <= state_next;
      done  <= done_next;
      if (meta_we) begin
        meta_valid[lv_q] <= 1'b1;
      end
      if (ne_we) begin
        nonempty[lv_q] <= ne_val;
      end
    end
  end

  // result payload, valid while done is high
  always_ff @(posedge clk) begin
    if (done_next) begin
      result <= result_next;
    end
  end

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == S_META || $past(state) == S_SLOT))
    else $error("result strobe without a finishing state");

  a_slot_after_meta: assert property (@(posedge clk) disable iff (rst)
    (state == S_SLOT) |-> ($past(state) == S_META))
    else $error("slot state not entered from metadata state");

  a_slot_port: assert property (@(posedge clk) disable iff (rst)
    !(slot_we && slot_re))
    else $error("slot memory read and written in the same cycle");

  a_nonempty_valid: assert property (@(posedge clk) disable iff (rst)
    (nonempty & ~meta_valid) == '0)
    else $error("nonempty level without written metadata");

  a_one_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> !done)
    else $error("result strobe right after acceptance");

endmodule
